@@ design/rgbhsl_pkg.sv @@
// Shared types, constants and the divider step for the RGB to HSL converter.
// Used by every module of the block; depends on nothing.
package rgbhsl_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned RemW  = 16;
  localparam int unsigned DivStages = 4;

  // Hue sector offsets on the 240 scale.
  localparam logic [7:0] HueBaseRed   = 8'd0;
  localparam logic [7:0] HueBaseGreen = 8'd80;
  localparam logic [7:0] HueBaseBlue  = 8'd160;
  localparam logic [7:0] HueBaseWrap  = 8'd240;

  // floor(8 * S / 17) equals (S * LightMul) >> LightShift for every S up to 510.
  localparam logic [11:0] LightMul   = 12'd3856;
  localparam int unsigned LightShift = 13;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_pixel_t;

  typedef struct packed {
    logic [ChanW-1:0] hue;
    logic [ChanW-1:0] saturation;
    logic [ChanW-1:0] lightness;
  } hsl_result_t;

  typedef struct packed {
    logic [RemW-1:0]  hue_rem;
    logic [ChanW-1:0] hue_q;
    logic [ChanW-1:0] hue_den;
    logic [ChanW-1:0] hue_base;
    logic             hue_sub;
    logic [RemW-1:0]  sat_rem;
    logic [ChanW-1:0] sat_q;
    logic [ChanW-1:0] sat_den;
    logic [ChanW-1:0] lightness;
    logic             grey;
  } hsl_job_t;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic            qbit;
  } div_step_t;

  // One restoring division step at quotient bit position sh.
  function automatic div_step_t div_step(logic [RemW-1:0] rem, logic [ChanW-1:0] den,
                                         logic [2:0] sh);
    logic [RemW+6:0] dsh;
    div_step_t       res;
    dsh = {15'd0, den} << sh;
    if ({7'd0, rem} >= dsh) begin
      res.rem  = rem - dsh[RemW-1:0];
      res.qbit = 1'b1;
    end else begin
      res.rem  = rem;
      res.qbit = 1'b0;
    end
    return res;
  endfunction

endpackage

@@ design/rgbhsl_front.sv @@
// Front end: registers an accepted pixel and classifies it into a division job.
// Depends on rgbhsl_pkg.
module rgbhsl_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  output logic                    full_o,
  input  rgbhsl_pkg::rgb_pixel_t  pixel_i,
  output logic                    job_valid_o,
  input  logic                    job_ready_i,
  output rgbhsl_pkg::hsl_job_t    job_o
);
  import rgbhsl_pkg::*;

  logic       vld_q, vld_d;
  rgb_pixel_t pix_q;
  logic       take;

  logic [7:0]  r, g, b, mx, mn, d, y;
  logic [8:0]  s;
  logic [8:0]  s_alt;
  logic [20:0] light_prod;
  logic [13:0] hue_num;
  logic [15:0] sat_num;
  logic        r_max, g_max;

  assign full_o = vld_q && !job_ready_i;
  assign take   = push_i && !full_o;
  assign vld_d  = take || (vld_q && !job_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      pix_q <= pixel_i;
    end
  end

  always_comb begin
    r = pix_q.red;
    g = pix_q.green;
    b = pix_q.blue;
    r_max = (r >= g) && (r >= b);
    g_max = !r_max && (g >= b);
    mx = r_max ? r : (g_max ? g : b);
    mn = (r <= g) ? ((r <= b) ? r : b) : ((g <= b) ? g : b);
    d = mx - mn;
    s = {1'b0, mx} + {1'b0, mn};
    s_alt = 9'd510 - s;
    light_prod = {12'd0, s} * {9'd0, LightMul};

    job_o = '0;
    if (r_max) begin
      job_o.hue_base = (g >= b) ? HueBaseRed : HueBaseWrap;
      job_o.hue_sub  = (g < b);
      y = (g >= b) ? (g - b) : (b - g);
    end else if (g_max) begin
      job_o.hue_base = HueBaseGreen;
      job_o.hue_sub  = (b < r);
      y = (b >= r) ? (b - r) : (r - b);
    end else begin
      job_o.hue_base = HueBaseBlue;
      job_o.hue_sub  = (r < g);
      y = (r >= g) ? (r - g) : (g - r);
    end
    hue_num = ({6'd0, y} << 5) + ({6'd0, y} << 3);
    sat_num = ({8'd0, d} << 8) - ({8'd0, d} << 4);

    job_o.hue_rem   = {2'd0, hue_num};
    job_o.hue_q     = '0;
    job_o.hue_den   = d;
    job_o.sat_rem   = sat_num;
    job_o.sat_q     = '0;
    job_o.sat_den   = (s <= 9'd255) ? s[7:0] : s_alt[7:0];
    job_o.lightness = light_prod[LightShift+7:LightShift];
    job_o.grey      = (d == 8'd0);
  end

  assign job_valid_o = vld_q;

endmodule

@@ design/rgbhsl_fifo.sv @@
// Two-entry queue that decouples the front end from the divider back end.
// Depends on rgbhsl_pkg.
module rgbhsl_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_valid_i,
  output logic                  wr_ready_o,
  input  rgbhsl_pkg::hsl_job_t  wr_data_i,
  output logic                  rd_valid_o,
  input  logic                  rd_ready_i,
  output rgbhsl_pkg::hsl_job_t  rd_data_o
);
  import rgbhsl_pkg::*;

  hsl_job_t   mem_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en, rd_en;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_ready_i && rd_valid_o;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_en ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd_en ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

`ifndef SYNTHESIS
  // The occupancy never exceeds the two entries.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue occupancy out of range");

  // Pointers agree with the occupancy.
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with occupancy");
`endif

endmodule

@@ design/rgbhsl_back.sv @@
// Back end: four-stage restoring divider pipeline for hue and saturation,
// followed by the result register. Depends on rgbhsl_pkg.
module rgbhsl_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    job_valid_i,
  output logic                    job_ready_o,
  input  rgbhsl_pkg::hsl_job_t    job_i,
  output logic                    empty_o,
  input  logic                    pop_i,
  output rgbhsl_pkg::hsl_result_t result_o
);
  import rgbhsl_pkg::*;

  hsl_job_t    st_q  [DivStages];
  hsl_job_t    nxt   [DivStages];
  hsl_job_t    src   [DivStages];
  logic        vld_q [DivStages];
  logic        vld_d [DivStages];
  logic        rdy   [DivStages];
  logic        src_vld [DivStages];
  div_step_t   hs_a, hs_b, ss_a, ss_b;
  logic        out_vld_q, out_vld_d, out_rdy;
  hsl_result_t res_q, res_d;
  logic        hue_up;

  assign out_rdy = !out_vld_q || pop_i;

  always_comb begin
    rdy[DivStages-1] = !vld_q[DivStages-1] || out_rdy;
    for (int k = DivStages - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign job_ready_o = rdy[0];

  always_comb begin
    hs_a = '0;
    hs_b = '0;
    ss_a = '0;
    ss_b = '0;
    for (int k = 0; k < DivStages; k++) begin
      src[k]     = (k == 0) ? job_i : st_q[(k == 0) ? 0 : k - 1];
      src_vld[k] = (k == 0) ? job_valid_i : vld_q[(k == 0) ? 0 : k - 1];
      hs_a = div_step(src[k].hue_rem, src[k].hue_den, 3'(7 - 2 * k));
      hs_b = div_step(hs_a.rem, src[k].hue_den, 3'(6 - 2 * k));
      ss_a = div_step(src[k].sat_rem, src[k].sat_den, 3'(7 - 2 * k));
      ss_b = div_step(ss_a.rem, src[k].sat_den, 3'(6 - 2 * k));
      nxt[k] = src[k];
      nxt[k].hue_rem = hs_b.rem;
      nxt[k].sat_rem = ss_b.rem;
      nxt[k].hue_q[7-2*k] = hs_a.qbit;
      nxt[k].hue_q[6-2*k] = hs_b.qbit;
      nxt[k].sat_q[7-2*k] = ss_a.qbit;
      nxt[k].sat_q[6-2*k] = ss_b.qbit;
      vld_d[k] = rdy[k] ? src_vld[k] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DivStages; k++) begin
        vld_q[k] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else begin
      for (int k = 0; k < DivStages; k++) begin
        vld_q[k] <= vld_d[k];
      end
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DivStages; k++) begin
      if (rdy[k] && src_vld[k]) begin
        st_q[k] <= nxt[k];
      end
    end
    if (out_rdy && vld_q[DivStages-1]) begin
      res_q <= res_d;
    end
  end

  always_comb begin
    hue_up = (st_q[DivStages-1].hue_rem != '0);
    out_vld_d = out_rdy ? vld_q[DivStages-1] : out_vld_q;
    res_d.lightness = st_q[DivStages-1].lightness;
    if (st_q[DivStages-1].grey) begin
      res_d.hue        = '0;
      res_d.saturation = '0;
    end else begin
      res_d.saturation = st_q[DivStages-1].sat_q;
      if (st_q[DivStages-1].hue_sub) begin
        res_d.hue = st_q[DivStages-1].hue_base - st_q[DivStages-1].hue_q
                    - {7'd0, hue_up};
      end else begin
        res_d.hue = st_q[DivStages-1].hue_base + st_q[DivStages-1].hue_q;
      end
    end
  end

  assign empty_o  = !out_vld_q;
  assign result_o = res_q;

`ifndef SYNTHESIS
  // A finished hue quotient never exceeds the 40 steps of one sector.
  a_hue_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[DivStages-1] && !st_q[DivStages-1].grey) |-> (st_q[DivStages-1].hue_q <= 8'd40))
    else $error("hue quotient out of sector range");

  // Every delivered result stays on the 240 scale, with hue short of a full turn.
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (res_q.hue < 8'd240 && res_q.saturation <= 8'd240
                   && res_q.lightness <= 8'd240))
    else $error("result out of range");

  // A result that is held back by the last stage is not dropped.
  a_last_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[DivStages-1] && !out_rdy) |=> vld_q[DivStages-1])
    else $error("stalled transaction lost in divider pipeline");
`endif

endmodule

@@ design/rgb_to_hsl_240.sv @@
// RGB to HSL converter on a 0..240 scale, top level.
// Instantiates rgbhsl_front, rgbhsl_fifo and rgbhsl_back; depends on rgbhsl_pkg.
//
// Usage:
//   Input channel: drive pixel_i and raise push; a transaction is taken at a
//   rising edge where push is high and full is low.
//   Result channel: while empty is low, result_o holds the oldest result; it is
//   taken at a rising edge where pop is high and empty is low.
//   Results leave in the order the pixels arrived, one result per pixel.
// Timing:
//   A pixel taken at an edge is loaded into the front register, then written
//   into the queue, passed through the four divider stages that produce two
//   quotient bits each for hue and saturation, and loaded into the result
//   register, where it is on result_o with empty low. Throughput is one pixel
//   per cycle while the result side does not stall; every stage then advances each cycle.
// Reset and stalls:
//   Reset empties the queue, the pipeline and the result register.
//   When pop stays low, stages fill behind the result register, the queue
//   fills, and full rises; nothing is lost and taking resumes once pop returns.
module rgb_to_hsl_240 (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  rgbhsl_pkg::rgb_pixel_t  pixel_i,
  output logic                    empty,
  input  logic                    pop,
  output rgbhsl_pkg::hsl_result_t result_o
);
  import rgbhsl_pkg::*;

  logic     f_valid, f_ready, b_valid, b_ready;
  hsl_job_t f_job, b_job;

  rgbhsl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .pixel_i     (pixel_i),
    .job_valid_o (f_valid),
    .job_ready_i (f_ready),
    .job_o       (f_job)
  );

  rgbhsl_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  (f_job),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_data_o  (b_job)
  );

  rgbhsl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (b_valid),
    .job_ready_o (b_ready),
    .job_i       (b_job),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result_o)
  );

endmodule
